>>> hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, codes and constants of the probability step sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Segment table geometry
    localparam int SEG_COUNT = 16;
    localparam int SEG_W     = $clog2(SEG_COUNT);

    // Field widths
    localparam int MODE_W    = 2;
    localparam int PHASE_W   = 8;
    localparam int DRAW_W    = 16;
    localparam int SLOT_W    = 4;
    localparam int PITCH_W   = 5;
    localparam int TICKS_W   = 5;
    localparam int LENGTH_W  = 4;
    localparam int CHANCE_W  = 5;
    localparam int TCOUNT_W  = 4;
    localparam int NOTE_W    = 7;
    localparam int ACTIVE_W  = 5;
    localparam int OFFSET_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_RESET  = 2'd2,
        MODE_WRITE  = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd2;

    // Configuration reset values
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 4'd0;
    localparam logic [NOTE_W-1:0]   BASE_RST   = 7'd24;

    // Segment field limits
    localparam logic [TICKS_W-1:0]  TICKS_MIN  = 5'd1;
    localparam logic [TICKS_W-1:0]  TICKS_MAX  = 5'd16;
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = 4'd10;
    localparam logic [CHANCE_W-1:0] CHANCE_MAX = 5'd20;
    localparam logic [NOTE_W-1:0]   NOTE_MAX   = 7'd127;

    // One segment table entry
    typedef struct packed {
        logic [PITCH_W-1:0]  pitch;
        logic [TICKS_W-1:0]  ticks;
        logic [LENGTH_W-1:0] length;
        logic [CHANCE_W-1:0] chance;
        logic                play;
    } seg_t;

    localparam seg_t SEG_RST = '{
        pitch:  5'd0,
        ticks:  5'd2,
        length: 4'd5,
        chance: 5'd20,
        play:   1'b1
    };

    // Registered command item
    typedef struct packed {
        mode_t               mode;
        logic [PHASE_W-1:0]  phase;
        logic                running;
        logic                first_tick;
        logic [DRAW_W-1:0]   random_draw;
        logic [SLOT_W-1:0]   write_slot;
        logic [PITCH_W-1:0]  write_pitch;
        logic [TICKS_W-1:0]  write_ticks;
        logic [LENGTH_W-1:0] write_length;
        logic [CHANCE_W-1:0] write_chance;
    } cmd_item_t;

    // Result item
    typedef struct packed {
        logic [SLOT_W-1:0] segment_now;
        logic              at_first;
        logic [NOTE_W-1:0] midi_note;
        logic              gate;
    } rsp_item_t;

    // Configuration register values
    typedef struct packed {
        logic [ACTIVE_W-1:0] active_segments;
        logic [OFFSET_W-1:0] pitch_offset;
        logic [NOTE_W-1:0]   note_base;
    } cfg_t;

endpackage

>>> hw/rtl/pss_cmd_if.sv
// ----------------------------------------------------------------------------
// pss_cmd_if
// Command channel: valid/ready with one sequencer command item.
// ----------------------------------------------------------------------------
interface pss_cmd_if
    import pss_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [PHASE_W-1:0]  phase;
    logic                running;
    logic                first_tick;
    logic [DRAW_W-1:0]   random_draw;
    logic [SLOT_W-1:0]   write_slot;
    logic [PITCH_W-1:0]  write_pitch;
    logic [TICKS_W-1:0]  write_ticks;
    logic [LENGTH_W-1:0] write_length;
    logic [CHANCE_W-1:0] write_chance;

    modport source (
        output valid, mode, phase, running, first_tick, random_draw,
               write_slot, write_pitch, write_ticks, write_length, write_chance,
        input  ready
    );

    modport sink (
        input  valid, mode, phase, running, first_tick, random_draw,
               write_slot, write_pitch, write_ticks, write_length, write_chance,
        output ready
    );
endinterface

>>> hw/rtl/pss_rsp_if.sv
// ----------------------------------------------------------------------------
// pss_rsp_if
// Result channel: valid/ready with one sequencer result item.
// ----------------------------------------------------------------------------
interface pss_rsp_if
    import pss_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] segment_now;
    logic              at_first;
    logic [NOTE_W-1:0] midi_note;
    logic              gate;

    modport source (
        output valid, segment_now, at_first, midi_note, gate,
        input  ready
    );

    modport sink (
        input  valid, segment_now, at_first, midi_note, gate,
        output ready
    );
endinterface

>>> hw/rtl/pss_cfg_if.sv
// ----------------------------------------------------------------------------
// pss_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface pss_cfg_if
    import pss_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hw/rtl/pss_cfg_regs.sv
// ----------------------------------------------------------------------------
// pss_cfg_regs
// Configuration registers: active length, transpose and note base.
// ----------------------------------------------------------------------------
module pss_cfg_regs
    import pss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; unknown indexes are dropped
    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                CFG_ACTIVE: cfg_next.active_segments = wr_data[ACTIVE_W-1:0];
                CFG_OFFSET: cfg_next.pitch_offset    = wr_data[OFFSET_W-1:0];
                CFG_BASE:   cfg_next.note_base       = wr_data[NOTE_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_segments <= ACTIVE_RST;
            cfg_reg.pitch_offset    <= OFFSET_RST;
            cfg_reg.note_base       <= BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/pss_in_reg.sv
// ----------------------------------------------------------------------------
// pss_in_reg
// Input register: captures one command item and holds it until the
// engine takes it.
// ----------------------------------------------------------------------------
module pss_in_reg
    import pss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd_item,
    output logic      item_valid,
    output cmd_item_t item,
    input  logic      take
);

    logic      valid_reg;
    logic      valid_next;
    cmd_item_t item_reg;

    // Free when empty or when the engine takes the held item this cycle
    assign cmd_ready  = !valid_reg || take;
    assign valid_next = (cmd_valid && cmd_ready) || (valid_reg && !take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd_item;
        end
    end

endmodule

>>> hw/rtl/pss_engine.sv
// ----------------------------------------------------------------------------
// pss_engine
// Segment table, position and tick state; computes note and gate of one
// item, updates the state and loads the result register.
// ----------------------------------------------------------------------------
module pss_engine
    import pss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  cmd_item_t item,
    input  cfg_t      cfg,
    output logic      take,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    localparam int DX_W  = DRAW_W + 6;   // draw * 40
    localparam int LHS_W = 16;
    localparam int LT_W  = LENGTH_W + TICKS_W;
    localparam int RHS_W = LT_W + 8;

    seg_t                seg_reg  [SEG_COUNT];
    seg_t                seg_next [SEG_COUNT];
    seg_t                seg_view [SEG_COUNT];
    logic [SEG_W-1:0]    pos_reg;
    logic [SEG_W-1:0]    pos_next;
    logic [TCOUNT_W-1:0] tick_reg;
    logic [TCOUNT_W-1:0] tick_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_item_t           rsp_item_reg;
    rsp_item_t           rsp_calc;

    seg_t                seg_wr;
    logic                wr_hit;
    logic [SEG_W-1:0]    slot_idx;
    logic                is_reset;
    logic                is_adv;
    logic [SEG_COUNT-1:0] play_cmp;
    logic [DX_W-1:0]     draw_x40;
    logic [SEG_W-1:0]    pos_eff;
    logic [TCOUNT_W-1:0] tick_eff;
    seg_t                cur;
    logic                play_cur;
    logic [NOTE_W:0]     note_sum;
    logic [PHASE_W-1:0]  ph;
    logic [LHS_W-1:0]    lhs;
    logic [LT_W-1:0]     len_ticks;
    logic [RHS_W-1:0]    rhs;
    logic [TICKS_W-1:0]  tick_inc;
    logic                seg_wrap;
    logic [SEG_W:0]      pos_inc;
    logic [SEG_W-1:0]    pos_adv;
    logic                enter;
    logic [SEG_W-1:0]    enter_idx;

    // Result register handshake
    assign take           = item_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid_next = take || (rsp_valid_reg && !rsp_ready);
    assign rsp_valid      = rsp_valid_reg;
    assign rsp_item       = rsp_item_reg;

    // Clamped segment write data; play bit is kept
    always_comb
    begin
        seg_wr.pitch = item.write_pitch;
        if (item.write_ticks < TICKS_MIN)
            seg_wr.ticks = TICKS_MIN;
        else if (item.write_ticks > TICKS_MAX)
            seg_wr.ticks = TICKS_MAX;
        else
            seg_wr.ticks = item.write_ticks;
        seg_wr.length = (item.write_length > LENGTH_MAX) ? LENGTH_MAX : item.write_length;
        seg_wr.chance = (item.write_chance > CHANCE_MAX) ? CHANCE_MAX : item.write_chance;
        seg_wr.play   = 1'b0;
    end

    assign slot_idx = SEG_W'(item.write_slot);
    assign wr_hit   = take && (item.mode == MODE_WRITE) && (32'(item.write_slot) < SEG_COUNT);
    assign is_reset = (item.mode == MODE_RESET);
    assign is_adv   = (item.mode == MODE_TICK) && !item.first_tick;

    // Play draw, one compare lane per entry: draw*40 <= (20 + chance) << 16
    assign draw_x40 = {item.random_draw, 6'b0} - {2'b0, item.random_draw, 4'b0}
                    - {2'b0, item.random_draw, 4'b0} + {3'b0, item.random_draw, 3'b0};

    always_comb
    begin
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            play_cmp[i] = draw_x40 <= {(6'(CHANCE_MAX) + 6'(seg_reg[i].chance)), 16'b0};
        end
    end

    // Table after this item's write
    always_comb
    begin
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            seg_view[i] = seg_reg[i];
            if (wr_hit && (slot_idx == SEG_W'(i)))
            begin
                seg_view[i]      = seg_wr;
                seg_view[i].play = seg_reg[i].play;
            end
        end
    end

    // Current segment, after a reset item
    assign pos_eff  = is_reset ? '0 : pos_reg;
    assign tick_eff = is_reset ? '0 : tick_reg;
    assign cur      = seg_view[pos_eff];
    assign play_cur = is_reset ? play_cmp[0] : cur.play;

    // Note with saturation
    assign note_sum = (NOTE_W+1)'(cfg.note_base) + (NOTE_W+1)'(cfg.pitch_offset)
                    + (NOTE_W+1)'(cur.pitch);

    // Gate: (tick*256 + ph)*10 <= length*ticks*256
    assign ph        = ({1'b0, tick_eff} != cur.ticks) ? item.phase : '0;
    assign lhs       = LHS_W'({tick_eff, ph}) * LHS_W'(10);
    assign len_ticks = LT_W'(cur.length) * LT_W'(cur.ticks);
    assign rhs       = {len_ticks, 8'b0};

    always_comb
    begin
        rsp_calc.segment_now = SLOT_W'(pos_eff);
        rsp_calc.at_first    = (pos_eff == '0);
        rsp_calc.midi_note   = (note_sum > (NOTE_W+1)'(NOTE_MAX)) ? NOTE_MAX
                                                                : note_sum[NOTE_W-1:0];
        rsp_calc.gate        = item.running && play_cur && (RHS_W'(lhs) <= rhs);
    end

    // Tick advance and segment wrap
    assign tick_inc = TICKS_W'(tick_reg) + TICKS_W'(1);
    assign seg_wrap = tick_inc >= cur.ticks;
    assign pos_inc  = (SEG_W+1)'(pos_reg) + (SEG_W+1)'(1);
    assign pos_adv  = ((32'(pos_inc) >= 32'(cfg.active_segments)) || (32'(pos_inc) >= SEG_COUNT))
                    ? '0 : pos_inc[SEG_W-1:0];

    assign enter     = take && (is_reset || (is_adv && seg_wrap));
    assign enter_idx = is_reset ? '0 : pos_adv;

    // Next state
    always_comb
    begin
        pos_next  = pos_reg;
        tick_next = tick_reg;
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            seg_next[i] = seg_view[i];
            if (enter && (enter_idx == SEG_W'(i)))
            begin
                seg_next[i].play = play_cmp[i];
            end
        end
        if (take)
        begin
            if (is_reset)
            begin
                pos_next  = '0;
                tick_next = '0;
            end
            else if (is_adv)
            begin
                if (seg_wrap)
                begin
                    pos_next  = pos_adv;
                    tick_next = '0;
                end
                else
                begin
                    tick_next = tick_inc[TCOUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEG_COUNT; i++)
            begin
                seg_reg[i] <= SEG_RST;
            end
            pos_reg       <= '0;
            tick_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < SEG_COUNT; i++)
            begin
                seg_reg[i] <= seg_next[i];
            end
            pos_reg       <= pos_next;
            tick_reg      <= tick_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_item_reg <= rsp_calc;
        end
    end

endmodule

>>> hw/rtl/probability_step_sequencer.sv
// ----------------------------------------------------------------------------
// probability_step_sequencer
// Sixteen-segment step sequencer with a random play gate per segment.
// ----------------------------------------------------------------------------
// Every command item yields exactly one result item. Commands pass through an
// input register and combinational table lookup, note sum and gate compare
// into a result register, so one item is taken every cycle while the result
// side keeps up; a result appears once its item has passed both registers, and
// the segment state updates as the result register loads, which holds the rate
// at one item per cycle. The result register stalls the command side only while
// a result waits and the input register is already full. Configuration writes
// are taken at once and should be issued only while no command is in flight.
module probability_step_sequencer
    import pss_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    pss_cmd_if.sink   cmd,
    pss_rsp_if.source rsp,
    pss_cfg_if.sink   cfg
);

    cmd_item_t cmd_item;
    cmd_item_t item;
    logic      item_valid;
    logic      take;
    cfg_t      cfg_val;
    rsp_item_t rsp_item;

    // Pack command fields
    always_comb
    begin
        cmd_item.mode         = mode_t'(cmd.mode);
        cmd_item.phase        = cmd.phase;
        cmd_item.running      = cmd.running;
        cmd_item.first_tick   = cmd.first_tick;
        cmd_item.random_draw  = cmd.random_draw;
        cmd_item.write_slot   = cmd.write_slot;
        cmd_item.write_pitch  = cmd.write_pitch;
        cmd_item.write_ticks  = cmd.write_ticks;
        cmd_item.write_length = cmd.write_length;
        cmd_item.write_chance = cmd.write_chance;
    end

    pss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    pss_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .cmd_item   (cmd_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    pss_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_val),
        .take       (take),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_item   (rsp_item)
    );

    // Unpack result fields
    assign rsp.segment_now = rsp_item.segment_now;
    assign rsp.at_first    = rsp_item.at_first;
    assign rsp.midi_note   = rsp_item.midi_note;
    assign rsp.gate        = rsp_item.gate;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the probability step sequencer. A transaction-level
// predictor tracks the segment table, position, tick count and registers, and
// queues the expected note/gate result for every command transfer. Directed
// tests cover first ticks, write clamping, play draw boundaries, stale tick
// counts and register extremes; random traffic follows under several mixes of
// sender gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import pss_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n;

    pss_cmd_if cmd_if ();
    pss_rsp_if rsp_if ();
    pss_cfg_if cfg_if ();

    probability_step_sequencer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Predicted sequencer state
    seg_t                seg_tab [SEG_COUNT];
    logic [SEG_W-1:0]    seq_pos;
    logic [TCOUNT_W-1:0] tick_cnt;
    cfg_t                seq_cfg;

    rsp_item_t   note_gate_q [$];
    rsp_item_t   want_rsp;
    int          fail_count = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_sequencer_state();
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            seg_tab[i] = SEG_RST;
        end
        seq_pos = '0;
        tick_cnt = '0;
        seq_cfg.active_segments = ACTIVE_RST;
        seq_cfg.pitch_offset = OFFSET_RST;
        seq_cfg.note_base = BASE_RST;
    endfunction

    // play = (2u - 1 <= chance/20) with u = draw/65536
    function automatic logic play_drawn(input logic [CHANCE_W-1:0] chance,
                                        input logic [DRAW_W-1:0] draw);
        int unsigned scaled_draw;
        int unsigned threshold;
        scaled_draw = draw;
        scaled_draw = scaled_draw * 40;
        threshold = chance;
        threshold = (threshold + 20) * 65536;
        return scaled_draw <= threshold;
    endfunction

    function automatic rsp_item_t predict_note_gate(input cmd_item_t c);
        seg_t        cur;
        rsp_item_t   r;
        int unsigned note, ph, tc, tk, ln, lhs, rhs, next_pos, next_tick;
        if (c.mode == MODE_WRITE)
        begin
            // Clamp to legal ranges, keep the play bit
            if (c.write_ticks < TICKS_MIN)
                seg_tab[c.write_slot].ticks = TICKS_MIN;
            else if (c.write_ticks > TICKS_MAX)
                seg_tab[c.write_slot].ticks = TICKS_MAX;
            else
                seg_tab[c.write_slot].ticks = c.write_ticks;
            seg_tab[c.write_slot].length = (c.write_length > LENGTH_MAX) ?
                                           LENGTH_MAX : c.write_length;
            seg_tab[c.write_slot].chance = (c.write_chance > CHANCE_MAX) ?
                                           CHANCE_MAX : c.write_chance;
            seg_tab[c.write_slot].pitch = c.write_pitch;
        end
        else if (c.mode == MODE_RESET)
        begin
            seq_pos = '0;
            tick_cnt = '0;
            seg_tab[0].play = play_drawn(seg_tab[0].chance, c.random_draw);
        end

        // Output reflects state before any tick advance
        cur = seg_tab[seq_pos];
        note = seq_cfg.note_base;
        note = note + seq_cfg.pitch_offset + cur.pitch;
        if (note > NOTE_MAX)
            note = NOTE_MAX;
        tc = tick_cnt;
        tk = cur.ticks;
        ln = cur.length;
        ph = (tc != tk) ? c.phase : 0;
        lhs = (tc * 256 + ph) * 10;
        rhs = ln * tk * 256;
        r.segment_now = seq_pos;
        r.at_first = (seq_pos == '0);
        r.midi_note = note[NOTE_W-1:0];
        r.gate = c.running && cur.play && (lhs <= rhs);

        // Tick advance, wrap at the active length, redraw on entry
        if (c.mode == MODE_TICK && !c.first_tick)
        begin
            next_tick = tc + 1;
            if (next_tick >= tk)
            begin
                next_pos = seq_pos;
                next_pos = next_pos + 1;
                tick_cnt = '0;
                if (next_pos >= seq_cfg.active_segments || next_pos >= SEG_COUNT)
                    next_pos = 0;
                seq_pos = next_pos[SEG_W-1:0];
                seg_tab[seq_pos].play = play_drawn(seg_tab[seq_pos].chance,
                                                   c.random_draw);
            end
            else
            begin
                tick_cnt = next_tick[TCOUNT_W-1:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic cmd_item_t op_item(input mode_t m, input logic [PHASE_W-1:0] ph,
                                          input logic run, input logic first,
                                          input logic [DRAW_W-1:0] draw);
        cmd_item_t c;
        c = '0;
        c.mode = m;
        c.phase = ph;
        c.running = run;
        c.first_tick = first;
        c.random_draw = draw;
        return c;
    endfunction

    function automatic cmd_item_t seg_write(input logic [SLOT_W-1:0] slot,
                                            input logic [PITCH_W-1:0] pitch,
                                            input logic [TICKS_W-1:0] ticks,
                                            input logic [LENGTH_W-1:0] len,
                                            input logic [CHANCE_W-1:0] chance,
                                            input logic [PHASE_W-1:0] ph);
        cmd_item_t c;
        c = op_item(MODE_WRITE, ph, 1'b1, 1'b0, 16'h0);
        c.write_slot = slot;
        c.write_pitch = pitch;
        c.write_ticks = ticks;
        c.write_length = len;
        c.write_chance = chance;
        return c;
    endfunction

    // Mostly ticks with short segments so wraps and redraws happen often
    function automatic cmd_item_t random_cmd();
        cmd_item_t   c;
        int unsigned pick;
        pick = $urandom_range(99);
        c.mode = (pick < 55) ? MODE_TICK : (pick < 75) ? MODE_SAMPLE :
                 (pick < 80) ? MODE_RESET : MODE_WRITE;
        c.phase = PHASE_W'($urandom_range(255));
        c.running = ($urandom_range(9) != 0);
        c.first_tick = ($urandom_range(15) == 0);
        c.random_draw = DRAW_W'($urandom_range(65535));
        c.write_slot = SLOT_W'($urandom_range(15));
        c.write_pitch = PITCH_W'(($urandom_range(9) == 0) ? $urandom_range(31) :
                                                            $urandom_range(24));
        pick = $urandom_range(9);
        c.write_ticks = TICKS_W'((pick < 7) ? $urandom_range(4, 1) :
                                 (pick < 9) ? $urandom_range(16, 1) : $urandom_range(31));
        c.write_length = LENGTH_W'(($urandom_range(7) == 0) ? $urandom_range(15) :
                                                              $urandom_range(10));
        c.write_chance = CHANCE_W'(($urandom_range(7) == 0) ? $urandom_range(31) :
                                                              $urandom_range(20));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_cmd(input cmd_item_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.mode <= c.mode;
        cmd_if.phase <= c.phase;
        cmd_if.running <= c.running;
        cmd_if.first_tick <= c.first_tick;
        cmd_if.random_draw <= c.random_draw;
        cmd_if.write_slot <= c.write_slot;
        cmd_if.write_pitch <= c.write_pitch;
        cmd_if.write_ticks <= c.write_ticks;
        cmd_if.write_length <= c.write_length;
        cmd_if.write_chance <= c.write_chance;
        cmd_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        note_gate_q.push_back(predict_note_gate(c));
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has been seen
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (note_gate_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.index <= idx;
        cfg_if.data <= val;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == CFG_ACTIVE)
            seq_cfg.active_segments = val[ACTIVE_W-1:0];
        else if (idx == CFG_OFFSET)
            seq_cfg.pitch_offset = val[OFFSET_W-1:0];
        else if (idx == CFG_BASE)
            seq_cfg.note_base = val[NOTE_W-1:0];
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_config(input int unsigned active, input int unsigned offset,
                                input int unsigned base);
        drain_results();
        write_reg(CFG_ACTIVE, active[CFG_DATA_W-1:0]);
        write_reg(CFG_OFFSET, offset[CFG_DATA_W-1:0]);
        write_reg(CFG_BASE, base[CFG_DATA_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (note_gate_q.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, actual seg %0d",
                         $time, rsp_if.segment_now);
                fail_count++;
            end
            else
            begin
                want_rsp = note_gate_q.pop_front();
                check_field("segment_now", want_rsp.segment_now, rsp_if.segment_now);
                check_field("at_first", want_rsp.at_first, rsp_if.at_first);
                check_field("midi_note", want_rsp.midi_note, rsp_if.midi_note);
                check_field("gate", want_rsp.gate, rsp_if.gate);
            end
        end
    end

    // Result back-pressure
    always @(negedge clk)
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_sample_and_first_tick();
        send_cmd(op_item(MODE_SAMPLE, 8'd0, 1'b1, 1'b0, 16'h1234));
        send_cmd(op_item(MODE_TICK, 8'd255, 1'b0, 1'b1, 16'hFFFF));
        send_cmd(op_item(MODE_TICK, 8'd255, 1'b1, 1'b0, 16'h0000));
        // Largest draw still plays at full chance
        send_cmd(op_item(MODE_TICK, 8'd128, 1'b1, 1'b0, 16'hFFFF));
    endtask

    task automatic test_segment_write_clamps();
        send_cmd(seg_write(4'd1, 5'd31, 5'd0, 4'd15, 5'd31, 8'd77));
        send_cmd(seg_write(4'd2, 5'd0, 5'd31, 4'd0, 5'd0, 8'd255));
        send_cmd(seg_write(4'd15, 5'd24, 5'd16, 4'd10, 5'd20, 8'd0));
    endtask

    task automatic test_reset_play_draws();
        send_cmd(op_item(MODE_RESET, 8'd10, 1'b1, 1'b0, 16'hFFFF));
        send_cmd(seg_write(4'd0, 5'd5, 5'd1, 4'd10, 5'd0, 8'd0));
        // Zero chance: 32768 is the last draw that plays
        send_cmd(op_item(MODE_RESET, 8'd0, 1'b1, 1'b0, 16'd32768));
        send_cmd(op_item(MODE_RESET, 8'd0, 1'b1, 1'b0, 16'd32769));
        send_cmd(op_item(MODE_TICK, 8'd0, 1'b1, 1'b0, 16'd0));
        send_cmd(op_item(MODE_TICK, 8'd0, 1'b1, 1'b0, 16'd30000));
    endtask

    // Shorten the running segment under the current tick count
    task automatic test_stale_tick_count();
        repeat (3) send_cmd(op_item(MODE_TICK, 8'd50, 1'b1, 1'b0, 16'd500));
        send_cmd(seg_write(4'd2, 5'd3, 5'd3, 4'd10, 5'd0, 8'd200));
        send_cmd(seg_write(4'd2, 5'd3, 5'd2, 4'd10, 5'd0, 8'd200));
        send_cmd(op_item(MODE_TICK, 8'd200, 1'b1, 1'b0, 16'd100));
    endtask

    task automatic test_config_extremes();
        // One active segment, note saturation
        apply_config(1, 15, 127);
        send_cmd(seg_write(4'd0, 5'd31, 5'd1, 4'd5, 5'd20, 8'd90));
        repeat (3) send_cmd(op_item(MODE_TICK, 8'd90, 1'b1, 1'b0, 16'd1000));
        // Zero active segments holds at the first segment
        drain_results();
        write_reg(CFG_ACTIVE, 7'd0);
        send_cmd(op_item(MODE_TICK, 8'd0, 1'b1, 1'b0, 16'd2000));
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int count);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            // One full pause halfway through
            if (i == count / 2)
                drain_results();
            send_cmd(random_cmd());
        end
        drain_results();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        rsp_if.ready = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.mode = MODE_SAMPLE;
        cmd_if.phase = '0;
        cmd_if.running = 1'b0;
        cmd_if.first_tick = 1'b0;
        cmd_if.random_draw = '0;
        cmd_if.write_slot = '0;
        cmd_if.write_pitch = '0;
        cmd_if.write_ticks = '0;
        cmd_if.write_length = '0;
        cmd_if.write_chance = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ACTIVE;
        cfg_if.data = '0;
        reset_sequencer_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_sample_and_first_tick();
        test_segment_write_clamps();
        test_reset_play_draws();
        test_stale_tick_count();
        test_config_extremes();

        apply_config(4, 11, 0);
        test_random_traffic(0, 0, 225);
        apply_config(16, 3, 60);
        test_random_traffic(84, 0, 225);
        apply_config(31, 7, 100);
        test_random_traffic(0, 84, 225);
        apply_config($urandom_range(16, 1), $urandom_range(11), $urandom_range(127));
        test_random_traffic(33, 33, 225);

        drain_results();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results still expected", $time, note_gate_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
